[design/pic_pkg.sv]
// Shared types and constants for the clamped PI regulator.
`default_nettype none

package pic_pkg;

    // Fixed-point format of feedback, reference, gains and the integral.
    localparam int FRAC_BITS = 16;

    // Field widths.
    localparam int GAIN_W  = 24;
    localparam int BOUND_W = 16;
    localparam int VAL_W   = 32;
    localparam int DRIVE_W = 16;

    // Signed error (VAL_W+1) times signed gain (GAIN_W+1).
    localparam int ERR_W  = VAL_W + 1;
    localparam int KS_W   = GAIN_W + 1;
    localparam int PROD_W = ERR_W + KS_W;
    // Product after the floor shift that drops the fraction of the gain.
    localparam int TERM_W = PROD_W - FRAC_BITS;
    // Clamped integral: bound shifted up by FRAC_BITS, plus a sign bit.
    localparam int INT_W  = BOUND_W + FRAC_BITS + 1;
    // Accumulator wide enough for integral plus two terms without overflow.
    localparam int ACC_W  = ((TERM_W > INT_W) ? TERM_W : INT_W) + 2;

    // Configuration port.
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    // Register indexes (byte address is 4 times the index).
    localparam logic [IDX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [IDX_W-1:0] REG_OUT_MIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_OUT_MAX  = 3'd3;
    localparam logic [IDX_W-1:0] REG_PROP_MEAS = 3'd4;
    localparam logic [IDX_W-1:0] REG_REVERSE  = 3'd5;

    // Item kinds carried on the input tuser.
    localparam logic KIND_COMPUTE = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [BOUND_W-1:0] out_min;
        logic [BOUND_W-1:0] out_max;
        logic               prop_on_measurement;
        logic               reverse_direction;
    } t_cfg;

endpackage

`default_nettype wire

[design/pi_controller_clamped.sv]
// Top level of the clamped PI regulator: stream ports, pipeline and integrator.
//
// Usage: each word on the input stream is one item. tuser holds the kind
// (compute or clear); tdata holds feedback in bits 31:0 and reference in
// bits 63:32, both signed fixed point with FRAC_BITS fractional bits.
// A compute item yields one output word, the drive value in bits 15:0;
// a clear item resets the integral, rearms seeding and yields nothing.
// The gains, bounds and mode bits are set through the APB-style port and
// should be written only while no items are in flight.
// From input acceptance to output valid an item passes through the input
// register, three gain multipliers, term select, integrator update, and
// the output add and clamp. One item per cycle is accepted for as long
// as the output side takes words; the integral feedback loop is a single
// add and clamp, so it closes through the integrator register alone.
// Reset empties the pipeline, loads the register defaults, zeroes the
// integral and arms seeding for the first compute item. When the receiver
// stalls, the output word holds and bubbles in the pipeline still fill;
// s_axis_tready drops once every stage is occupied.
`default_nettype none

module pi_controller_clamped (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Input stream.
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [63:0]                 s_axis_tdata,  // feedback, reference
    input  wire logic                        s_axis_tuser,  // kind
    // Output stream.
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [15:0]                 m_axis_tdata,  // drive
    // Configuration port.
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pic_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [pic_pkg::DATA_W-1:0]  pwdata,
    output logic      [pic_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);
    import pic_pkg::*;

    // Saturate to [lo, hi] scaled by the fraction; above hi wins first.
    function automatic logic signed [ACC_W-1:0] clamp_range(
        input logic signed [ACC_W-1:0] v,
        input logic [BOUND_W-1:0]      lo,
        input logic [BOUND_W-1:0]      hi
    );
        logic signed [ACC_W-1:0] hi_v;
        logic signed [ACC_W-1:0] lo_v;
        hi_v = signed'({{(ACC_W-BOUND_W-FRAC_BITS){1'b0}}, hi, {FRAC_BITS{1'b0}}});
        lo_v = signed'({{(ACC_W-BOUND_W-FRAC_BITS){1'b0}}, lo, {FRAC_BITS{1'b0}}});
        if (v > hi_v) begin
            clamp_range = hi_v;
        end else if (v < lo_v) begin
            clamp_range = lo_v;
        end else begin
            clamp_range = v;
        end
    endfunction

    t_cfg cfg;

    pic_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Stage valids and load enables; a stage loads when empty or draining.
    logic r_v1, r_v2, r_v3, r_v4, r_o_valid;
    logic ld1, ld2, ld3, ld4, ld_o;

    assign ld_o = !r_o_valid || m_axis_tready;
    assign ld4  = !r_v4 || ld_o;
    assign ld3  = !r_v3 || ld4;
    assign ld2  = !r_v2 || ld3;
    assign ld1  = !r_v1 || ld2;

    assign s_axis_tready = ld1;

    // Stage 1: input register.
    logic                      r_k1;
    logic signed [VAL_W-1:0]   r_fb1;
    logic signed [VAL_W-1:0]   r_ref1;

    // Seeding state and last measurement, tracked as items leave stage 1.
    logic                      r_f_seed;
    logic signed [VAL_W-1:0]   r_f_prev;

    // Stage 2: products.
    logic                      r_k2;
    logic                      r_seed2;
    logic signed [VAL_W-1:0]   r_fb2;
    logic signed [TERM_W-1:0]  r_ti2;
    logic signed [TERM_W-1:0]  r_tp2;
    logic signed [TERM_W-1:0]  r_te2;

    // Stage 3: integral increment and proportional-on-error term.
    logic                      r_k3;
    logic                      r_seed3;
    logic signed [VAL_W-1:0]   r_fb3;
    logic signed [TERM_W:0]    r_delta3;
    logic signed [TERM_W-1:0]  r_pe3;

    // Integrator state.
    logic signed [INT_W-1:0]   r_integ;

    // Stage 4: updated integral and output term.
    logic                      r_k4;
    logic signed [INT_W-1:0]   r_integ4;
    logic signed [TERM_W-1:0]  r_pe4;

    // Output register.
    logic [DRIVE_W-1:0]        r_drive;

    // Product inputs; seeding takes the previous input from the reference.
    logic signed [KS_W-1:0]    kp;
    logic signed [KS_W-1:0]    ki;
    logic signed [VAL_W-1:0]   prev_sel;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   din;
    logic signed [PROD_W-1:0]  prod_i;
    logic signed [PROD_W-1:0]  prod_p;
    logic signed [PROD_W-1:0]  prod_e;

    always_comb begin
        kp = cfg.reverse_direction ? -signed'({1'b0, cfg.gain_p})
                                   :  signed'({1'b0, cfg.gain_p});
        ki = cfg.reverse_direction ? -signed'({1'b0, cfg.gain_i})
                                   :  signed'({1'b0, cfg.gain_i});
        prev_sel = r_f_seed ? r_ref1 : r_f_prev;
        err      = ERR_W'(r_ref1) - ERR_W'(r_fb1);
        din      = ERR_W'(r_fb1) - ERR_W'(prev_sel);
        prod_i   = PROD_W'(ki) * PROD_W'(err);
        prod_p   = PROD_W'(kp) * PROD_W'(din);
        prod_e   = PROD_W'(kp) * PROD_W'(err);
    end

    // Integrator update: seed from clamped feedback, add increment, clamp.
    logic signed [INT_W-1:0]   integ_base;
    logic signed [ACC_W-1:0]   integ_sum;
    logic signed [ACC_W-1:0]   integ_clamped;
    logic signed [INT_W-1:0]   n_integ;
    logic signed [ACC_W-1:0]   seed_clamped;

    always_comb begin
        seed_clamped  = clamp_range(ACC_W'(r_fb3), cfg.out_min, cfg.out_max);
        integ_base    = r_seed3 ? seed_clamped[INT_W-1:0] : r_integ;
        integ_sum     = ACC_W'(integ_base) + ACC_W'(r_delta3);
        integ_clamped = clamp_range(integ_sum, cfg.out_min, cfg.out_max);
        n_integ       = integ_clamped[INT_W-1:0];
    end

    // Output: add the error term, saturate, keep the integer part.
    logic signed [ACC_W-1:0]   out_sum;
    logic signed [ACC_W-1:0]   out_clamped;
    logic [DRIVE_W-1:0]        n_drive;

    always_comb begin
        out_sum     = ACC_W'(r_pe4) + ACC_W'(r_integ4);
        out_clamped = clamp_range(out_sum, cfg.out_min, cfg.out_max);
        n_drive     = out_clamped[FRAC_BITS+DRIVE_W-1:FRAC_BITS];
    end

    // Pipeline valids, seeding tracker and integrator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_o_valid <= 1'b0;
            r_f_seed  <= 1'b1;
            r_integ   <= '0;
        end else begin
            if (ld1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
            if (ld4) begin
                r_v4 <= r_v3;
            end
            if (ld_o) begin
                r_o_valid <= r_v4 && (r_k4 == KIND_COMPUTE);
            end
            if (r_v1 && ld2) begin
                r_f_seed <= (r_k1 == KIND_CLEAR);
            end
            if (r_v3 && ld4) begin
                r_integ <= (r_k3 == KIND_CLEAR) ? '0 : n_integ;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_k1   <= s_axis_tuser;
            r_fb1  <= signed'(s_axis_tdata[VAL_W-1:0]);
            r_ref1 <= signed'(s_axis_tdata[2*VAL_W-1:VAL_W]);
        end
        if (r_v1 && ld2) begin
            r_f_prev <= r_fb1;
        end
        if (ld2) begin
            r_k2    <= r_k1;
            r_seed2 <= r_f_seed;
            r_fb2   <= r_fb1;
            r_ti2   <= prod_i[PROD_W-1:FRAC_BITS];
            r_tp2   <= prod_p[PROD_W-1:FRAC_BITS];
            r_te2   <= prod_e[PROD_W-1:FRAC_BITS];
        end
        if (ld3) begin
            r_k3     <= r_k2;
            r_seed3  <= r_seed2;
            r_fb3    <= r_fb2;
            r_delta3 <= cfg.prop_on_measurement ? ((TERM_W+1)'(r_ti2) - (TERM_W+1)'(r_tp2))
                                                :  (TERM_W+1)'(r_ti2);
            r_pe3    <= cfg.prop_on_measurement ? '0 : r_te2;
        end
        if (ld4) begin
            r_k4     <= r_k3;
            r_integ4 <= n_integ;
            r_pe4    <= r_pe3;
        end
        if (ld_o) begin
            r_drive <= n_drive;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_drive;

    // The clamped integral can never go negative, both bounds being unsigned.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_integ[INT_W-1])
        else $error("integral state went negative");

    // Input back-pressure only when every stage and the output are full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_o_valid && !m_axis_tready))
        else $error("input stalled while the pipeline had room");

    // A word left in stage 4 while the output drains must have moved on.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && m_axis_tready && !r_v3) |=> !r_v4)
        else $error("stage 4 did not drain");

endmodule

`default_nettype wire

[design/pic_regs.sv]
// Configuration register file with an APB-style access port.
`default_nettype none

module pic_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pic_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [pic_pkg::DATA_W-1:0]  pwdata,
    output logic      [pic_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output pic_pkg::t_cfg                    o_cfg
);
    import pic_pkg::*;

    t_cfg             r_cfg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p              <= '0;
            r_cfg.gain_i              <= '0;
            r_cfg.out_min             <= '0;
            r_cfg.out_max             <= '1;
            r_cfg.prop_on_measurement <= 1'b1;
            r_cfg.reverse_direction   <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_GAIN_P:    r_cfg.gain_p              <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:    r_cfg.gain_i              <= pwdata[GAIN_W-1:0];
                REG_OUT_MIN:   r_cfg.out_min             <= pwdata[BOUND_W-1:0];
                REG_OUT_MAX:   r_cfg.out_max             <= pwdata[BOUND_W-1:0];
                REG_PROP_MEAS: r_cfg.prop_on_measurement <= pwdata[0];
                REG_REVERSE:   r_cfg.reverse_direction   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (idx)
            REG_GAIN_P:    prdata = DATA_W'(r_cfg.gain_p);
            REG_GAIN_I:    prdata = DATA_W'(r_cfg.gain_i);
            REG_OUT_MIN:   prdata = DATA_W'(r_cfg.out_min);
            REG_OUT_MAX:   prdata = DATA_W'(r_cfg.out_max);
            REG_PROP_MEAS: prdata = DATA_W'(r_cfg.prop_on_measurement);
            REG_REVERSE:   prdata = DATA_W'(r_cfg.reverse_direction);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire
